// File: rtl/laws_mask_convolution_defines.svh
// Assertion macros used by the checker file.
`ifndef LAWS_MASK_CONVOLUTION_DEFINES_SVH
`define LAWS_MASK_CONVOLUTION_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge of clk.
`define LMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk.
`define LMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lmc_pkg.sv
`timescale 1ns / 1ps
package lmc_pkg;

  localparam int PIX_W          = 8;
  localparam int DIM_W          = 13;
  localparam int CFG_W          = 9;
  localparam int IDX_W          = 2;
  localparam int VSEL_W         = 3;
  localparam int OUT_W          = 17;
  localparam int HS_W           = 16;
  localparam int SUM_W          = 24;
  localparam int NORM_SHIFT     = 8;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int Q_DEPTH        = 4;
  localparam int QCNT_W         = $clog2(Q_DEPTH + 1);

  localparam logic [IDX_W-1:0] REG_ROW_VECTOR    = 2'd0;
  localparam logic [IDX_W-1:0] REG_COLUMN_VECTOR = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 2'd2;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd3;

  localparam logic [VSEL_W-1:0] SEL_L5 = 3'd0;
  localparam logic [VSEL_W-1:0] SEL_R5 = 3'd4;

  localparam logic signed [OUT_W-1:0] FILT_MAX = 17'sd65280;
  localparam logic signed [OUT_W-1:0] FILT_MIN = -17'sd65280;

  localparam logic signed [3:0] LAWS_VEC [5][5] = '{
    '{4'sd1,  4'sd4,  4'sd6, 4'sd4,  4'sd1},
    '{-4'sd1, -4'sd2, 4'sd0, 4'sd2,  4'sd1},
    '{-4'sd1, 4'sd0,  4'sd2, 4'sd0,  -4'sd1},
    '{-4'sd1, 4'sd2,  4'sd0, -4'sd2, 4'sd1},
    '{4'sd1,  -4'sd4, 4'sd6, -4'sd4, 4'sd1}
  };

  typedef logic [4:0][4:0][PIX_W-1:0] lmc_win_t;

  // One classified window on its way to the arithmetic.
  typedef struct packed {
    lmc_win_t                win;
    logic [4:0][2:0]         rslot;
    logic [4:0][2:0]         cslot;
    logic [VSEL_W-1:0]       rv;
    logic [VSEL_W-1:0]       cv;
    logic                    last;
  } lmc_rec_t;

  localparam int REC_W = $bits(lmc_rec_t);

  function automatic logic signed [3:0] laws_coef(input logic [VSEL_W-1:0] v,
                                                  input logic [2:0] i);
    return LAWS_VEC[v][i];
  endfunction

  // Window slot for coordinate pos+k-2, mirrored without repeating the edge.
  function automatic logic [2:0] mirror_slot(input logic [DIM_W-1:0] pos,
                                             input logic [2:0] k,
                                             input logic [DIM_W-1:0] n);
    logic signed [DIM_W+1:0] p;
    logic signed [DIM_W+1:0] nn;
    logic signed [DIM_W+1:0] x;
    p  = signed'({2'b00, pos});
    nn = signed'({2'b00, n});
    x  = p + signed'({{(DIM_W-1){1'b0}}, k}) - (DIM_W+2)'(2);
    if (x < 0) x = -x;
    if (x >= nn) x = ((nn - (DIM_W+2)'(1)) <<< 1) - x;
    x = x - p + (DIM_W+2)'(2);
    return x[2:0];
  endfunction

endpackage

// File: rtl/lmc_if.sv
`timescale 1ns / 1ps
interface lmc_stream_if import lmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, command, pixel, input ready);
  modport sink (input valid, command, pixel, output ready);
endinterface

interface lmc_result_if import lmc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered;
  logic                    last_of_frame;
  modport source (output valid, filtered, last_of_frame, input ready);
  modport sink (input valid, filtered, last_of_frame, output ready);
endinterface

// File: rtl/lmc_queue.sv
`timescale 1ns / 1ps
module lmc_queue import lmc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = Q_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

// File: rtl/lmc_front.sv
`timescale 1ns / 1ps
module lmc_front import lmc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  lmc_stream_if.sink        stream,
  input  logic              cfg_write,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [QCNT_W-1:0] q_count,
  output logic              push,
  output lmc_rec_t          push_rec
);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CMP_W = 2 * DIM_W + 1;
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT) + 2;
  localparam int DVC_W = $clog2(CNT_W + 1);

  logic [VSEL_W-1:0] row_vector, column_vector;
  logic [CFG_W-1:0]  frame_width, frame_height;

  logic [CNT_W-1:0] item_count;
  logic [CW-1:0]    col;
  logic [1:0]       bank;
  logic [RW-1:0]    out_row;
  logic [CW-1:0]    out_col;

  logic [DIM_W-1:0] w, h, wx, hx, r_pos, c_pos, orow_x, ocol_x;
  logic [CMP_W-1:0] area, lag, cnt_x;
  logic             acc, emit, store_en, last;
  logic [PIX_W-1:0] pix;
  logic [4:0][2:0]  rslot, cslot;

  logic              a_valid, a_emit, a_last;
  logic [PIX_W-1:0]  a_pix;
  logic [1:0]        a_bank;
  logic [4:0][2:0]   a_rslot, a_cslot;
  logic [VSEL_W-1:0] a_rv, a_cv;
  logic [PIX_W-1:0]  rd [4];
  lmc_win_t          win, win_next;

  // Column and bank recomputed from item_count after a register write.
  logic              dv_load, dv_done, dv_fit, realign;
  logic [DVC_W-1:0]  dv_cnt;
  logic [CNT_W-1:0]  dv_q;
  logic [DIM_W-1:0]  dv_rem;
  logic [DIM_W:0]    dv_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vector    <= SEL_L5;
      column_vector <= SEL_L5;
      frame_width   <= CFG_W'(256);
      frame_height  <= CFG_W'(256);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_VECTOR:    row_vector    <= cfg_data[VSEL_W-1:0];
        REG_COLUMN_VECTOR: column_vector <= cfg_data[VSEL_W-1:0];
        REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    wx = DIM_W'(frame_width);
    hx = DIM_W'(frame_height);
    w  = (wx < DIM_W'(3)) ? DIM_W'(3) : (wx > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : wx;
    h  = (hx < DIM_W'(3)) ? DIM_W'(3) : (hx > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : hx;
    area  = CMP_W'(w * h);
    lag   = CMP_W'({w, 1'b0}) + CMP_W'(2);
    cnt_x = CMP_W'(item_count);
    emit     = cnt_x >= lag;
    store_en = cnt_x < area;
    orow_x = DIM_W'(out_row);
    ocol_x = DIM_W'(out_col);
    r_pos  = (orow_x < h - 1'b1) ? orow_x : h - 1'b1;
    c_pos  = (ocol_x < w - 1'b1) ? ocol_x : w - 1'b1;
    last   = emit && (r_pos == h - 1'b1) && (c_pos == w - 1'b1);
    pix    = stream.command ? '0 : stream.pixel;
    for (int k = 0; k < 5; k++) begin
      rslot[k] = mirror_slot(r_pos, 3'(k), h);
      cslot[k] = mirror_slot(c_pos, 3'(k), w);
    end
  end

  // One restoring step of item_count / w per cycle.
  assign dv_trial = {dv_rem, dv_q[CNT_W-1]};
  assign dv_fit   = dv_trial >= {1'b0, w};
  assign realign  = dv_load | (dv_cnt != '0) | dv_done;

  // Room for the item in flight plus the new one; closed while realigning.
  assign stream.ready = !realign &&
      (({1'b0, q_count} + {{QCNT_W{1'b0}}, a_valid}) < (QCNT_W+1)'(Q_DEPTH));
  assign acc = stream.valid & stream.ready;

  // Four row banks; row i of the incoming column comes from bank (row+i) mod 4.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] bank_mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (acc) begin
        rd[b] <= bank_mem[col];
        if (store_en && bank == 2'(b)) bank_mem[col] <= pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      col        <= '0;
      bank       <= '0;
      out_row    <= '0;
      out_col    <= '0;
      a_valid    <= 1'b0;
      dv_load    <= 1'b0;
      dv_done    <= 1'b0;
      dv_cnt     <= '0;
      dv_q       <= '0;
      dv_rem     <= '0;
    end else begin
      a_valid <= acc;
      dv_load <= cfg_write;
      dv_done <= (dv_cnt == DVC_W'(1));
      if (dv_load) begin
        dv_q   <= item_count;
        dv_rem <= '0;
        dv_cnt <= DVC_W'(CNT_W);
      end else if (dv_cnt != '0) begin
        dv_q   <= {dv_q[CNT_W-2:0], dv_fit};
        dv_rem <= dv_fit ? DIM_W'(dv_trial - {1'b0, w}) : DIM_W'(dv_trial);
        dv_cnt <= dv_cnt - 1'b1;
      end
      if (dv_done) begin
        col  <= CW'(dv_rem);
        bank <= dv_q[1:0];
      end
      if (acc) begin
        if (last) begin
          item_count <= '0;
          col        <= '0;
          bank       <= '0;
          out_row    <= '0;
          out_col    <= '0;
        end else begin
          item_count <= item_count + 1'b1;
          if (DIM_W'(col) + 1'b1 >= w) begin
            col  <= '0;
            bank <= bank + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
          if (emit) begin
            if (ocol_x + 1'b1 >= w) begin
              out_col <= '0;
              out_row <= out_row + 1'b1;
            end else begin
              out_col <= out_col + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_pix   <= pix;
      a_bank  <= bank;
      a_emit  <= emit;
      a_last  <= last;
      a_rslot <= rslot;
      a_cslot <= cslot;
      a_rv    <= (row_vector > SEL_R5) ? SEL_R5 : row_vector;
      a_cv    <= (column_vector > SEL_R5) ? SEL_R5 : column_vector;
    end
  end

  // Shift the window left and bring in the new column.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) win_next[i][j] = win[i][j+1];
    end
    for (int i = 0; i < 4; i++) win_next[i][4] = rd[2'(a_bank + 2'(i))];
    win_next[4][4] = a_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) win <= '0;
    else if (a_valid) win <= win_next;
  end

  assign push = a_valid & a_emit;
  always_comb begin
    push_rec.win   = win_next;
    push_rec.rslot = a_rslot;
    push_rec.cslot = a_cslot;
    push_rec.rv    = a_rv;
    push_rec.cv    = a_cv;
    push_rec.last  = a_last;
  end
endmodule

// File: rtl/lmc_back.sv
`timescale 1ns / 1ps
module lmc_back import lmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  lmc_rec_t          rec,
  input  logic [QCNT_W-1:0] q_count,
  output logic              pop,
  lmc_result_if.source      result
);
  logic                           v1, v2, div1;
  logic signed [4:0][HS_W-1:0]    hsum1;
  logic [VSEL_W-1:0]              rv1;
  logic                           last1, last2;
  logic signed [OUT_W-1:0]        res2;
  logic signed [4:0][HS_W-1:0]    hsum;
  logic signed [SUM_W-1:0]        sum;
  logic [QCNT_W-1:0]              o_count;
  logic [OUT_W:0]                 o_data;
  logic                           o_pop;

  // Take a window only when the output queue can absorb everything in flight.
  assign pop = (q_count != '0) &&
               (({1'b0, o_count} + (QCNT_W+1)'(v1) + (QCNT_W+1)'(v2)) < (QCNT_W+1)'(Q_DEPTH));

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      hsum[k] = '0;
      for (int l = 0; l < 5; l++) begin
        hsum[k] = hsum[k] + HS_W'(laws_coef(rec.cv, 3'(l)) *
                  signed'({1'b0, rec.win[rec.rslot[k]][rec.cslot[l]]}));
      end
    end
    sum = '0;
    for (int k = 0; k < 5; k++) begin
      sum = sum + SUM_W'(laws_coef(rv1, 3'(k)) * signed'(hsum1[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= pop;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hsum1 <= hsum;
      rv1   <= rec.rv;
      div1  <= (rec.rv == SEL_L5) && (rec.cv == SEL_L5);
      last1 <= rec.last;
    end
    if (v1) begin
      // L5xL5 sums to 256 and is never negative: a shift divides exactly.
      res2  <= div1 ? OUT_W'(sum >>> NORM_SHIFT) : OUT_W'(sum);
      last2 <= last1;
    end
  end

  lmc_queue #(.WIDTH(OUT_W + 1), .DEPTH(Q_DEPTH)) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (v2),
    .push_data ({last2, res2}),
    .pop       (o_pop),
    .pop_data  (o_data),
    .count     (o_count)
  );

  assign o_pop                = result.valid & result.ready;
  assign result.valid         = o_count != '0;
  assign result.filtered      = o_data[OUT_W-1:0];
  assign result.last_of_frame = o_data[OUT_W];
endmodule

// File: rtl/laws_mask_convolution.sv
`timescale 1ns / 1ps
// Channel    Dir   Payload                          Transfer
// stream     in    command, pixel[7:0]              valid & ready at rising clk
// result     out   filtered[16:0] s, last_of_frame  valid & ready at rising clk
// cfg        in    cfg_index[1:0], cfg_data[8:0]    cfg_write at rising clk
//
// One pixel per clock while stream.ready is high; each result passes both queues.
// The per-item rate is set by the single write/read port of each row bank.
// Results begin 2*width+2 items into a frame; drain items flush the tail.
// rst is synchronous, active high; it clears counters, queues and window.
// Either side may stall freely: the classify queue and output queue absorb it.
// Each register write holds stream.ready low while it realigns the column.
module laws_mask_convolution import lmc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  lmc_stream_if.sink       stream,
  lmc_result_if.source     result,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  logic              push, pop;
  lmc_rec_t          push_rec, pop_rec;
  logic [REC_W-1:0]  pop_bits;
  logic [QCNT_W-1:0] q_count;

  // Front: accept pixels, keep the row banks and the 5x5 window, classify.
  lmc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_count   (q_count),
    .push      (push),
    .push_rec  (push_rec)
  );

  // Hold classified windows between the two halves.
  lmc_queue #(.WIDTH(REC_W), .DEPTH(Q_DEPTH)) u_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_rec),
    .pop       (pop),
    .pop_data  (pop_bits),
    .count     (q_count)
  );

  assign pop_rec = lmc_rec_t'(pop_bits);

  // Back: mirror-select, multiply-accumulate, normalize, deliver.
  lmc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .rec     (pop_rec),
    .q_count (q_count),
    .pop     (pop),
    .result  (result)
  );
endmodule

// File: rtl/lmc_checker.sv
`timescale 1ns / 1ps
`include "laws_mask_convolution_defines.svh"
module lmc_checker import lmc_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] filtered,
  input logic                    last_of_frame
);
  `LMC_ASSERT_NEXT(a_reset_quiet, rst, !out_valid, "result valid right after reset")
  `LMC_ASSERT_NEXT(a_reset_ready, rst, in_ready, "stream not ready after reset")
  `LMC_ASSERT_NOW(a_range, !rst && out_valid, (filtered <= FILT_MAX) && (filtered >= FILT_MIN), "filtered out of range")
  `LMC_ASSERT_NEXT(a_hold, !rst && out_valid && !out_ready, out_valid && $stable(filtered) && $stable(last_of_frame), "stalled result changed")
endmodule

bind laws_mask_convolution lmc_checker u_lmc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (stream.valid),
  .in_ready      (stream.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .filtered      (result.filtered),
  .last_of_frame (result.last_of_frame)
);
